/* src/zctr_pkg.sv */
// ----------------------------------------------------------------------------
// zctr_pkg: shared types and constants for the zero-cross timestamp rings
// Command and register codes, item structs, bank control structs and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package zctr_pkg;

  // sizes
  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam int unsigned PHASE_CNT      = 3;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned WORD_W         = 32;

  // configuration reset values
  localparam logic [WORD_W-1:0] TIME_OFFSET_RST  = 32'hFFFF_C389;  // -15479
  localparam logic [WORD_W-1:0] MIN_GAP_RST      = 32'd125000;
  localparam logic [WORD_W-1:0] HALF_CYCLE_RST   = 32'd250000;
  localparam logic [PHASE_CNT-1:0] NEG_PIN_MASK_RST = 3'b000;

  // phase code with no ring behind it
  localparam logic [1:0] PHASE_NONE = 2'd3;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_TIME_OFFSET  = 2'd0,
    CFG_MIN_GAP      = 2'd1,
    CFG_HALF_CYCLE   = 2'd2,
    CFG_NEG_PIN_MASK = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [1:0]        phase;
    logic              falling;
    logic [WORD_W-1:0] stamp;
    logic [2:0]        slot;
  } in_item_t;

  typedef struct packed {
    logic              rise_stored;
    logic              fall_stored;
    logic [IDX_W-1:0]  wr_index;
    logic [IDX_W-1:0]  rd_index;
    logic [WORD_W-1:0] entry;
  } out_item_t;

  // lookup issued to a bank in the accept cycle
  typedef struct packed {
    logic       en;
    logic       is_read;
    logic [1:0] phase;
    logic [2:0] slot;
  } bank_rd_t;

  // update applied to a bank in the execute cycle
  typedef struct packed {
    logic       commit;
    logic       try_store;
    logic       clear;
    logic [1:0] phase;
    logic [2:0] slot;
  } bank_op_t;

  // bank status seen in the execute cycle
  typedef struct packed {
    logic              stored;
    logic [IDX_W-1:0]  wr_index;
    logic [IDX_W-1:0]  rd_index;
    logic [WORD_W-1:0] entry;
  } bank_rsp_t;

  // keep a phase code inside the pointer arrays
  function automatic logic [1:0] phase_clamp(input logic [1:0] ph);
    return (ph == PHASE_NONE) ? 2'd0 : ph;
  endfunction

endpackage

/* src/zctr_ram.sv */
// ----------------------------------------------------------------------------
// zctr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
module zctr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/zctr_bank.sv */
// ----------------------------------------------------------------------------
// zctr_bank: one edge side (rising or falling) of all three phases
// Holds the ring words in a RAM and the write/read pointers in flops.
// Looks up the newest entry (or a read slot), then checks the gap and
// writes the new word back in the execute cycle.
// ----------------------------------------------------------------------------
module zctr_bank #(
  parameter int unsigned RING_DEPTH = zctr_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [zctr_pkg::WORD_W-1:0]   min_gap,
  input  zctr_pkg::bank_rd_t            rd_req,
  input  zctr_pkg::bank_op_t            op,
  input  logic [zctr_pkg::WORD_W-1:0]   word,
  output zctr_pkg::bank_rsp_t           rsp
);

  localparam int unsigned PTR_W     = $clog2(RING_DEPTH);
  localparam int unsigned RAM_DEPTH = zctr_pkg::PHASE_CNT * (2 ** PTR_W);
  localparam int unsigned ADDR_W    = PTR_W + 2;
  localparam int unsigned EXT_W     = PTR_W + 3;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // pointer file, one set per phase
  logic [PTR_W-1:0]                 wp_r [zctr_pkg::PHASE_CNT];
  logic [PTR_W-1:0]                 rp_r [zctr_pkg::PHASE_CNT];
  logic [zctr_pkg::PHASE_CNT-1:0]   wrap_r;

  logic [1:0]                       rd_ph;
  logic [ADDR_W-1:0]                raddr;
  logic [ADDR_W-1:0]                waddr;
  logic [zctr_pkg::WORD_W-1:0]      rdata;

  logic [1:0]                       ph;
  logic [PTR_W-1:0]                 cur_wp;
  logic [PTR_W-1:0]                 cur_rp;
  logic                             cur_wrap;
  logic [PTR_W-1:0]                 wp_adv;
  logic [PTR_W-1:0]                 rp_adv;
  logic [PTR_W-1:0]                 new_wp;
  logic [PTR_W-1:0]                 new_rp;
  logic [zctr_pkg::WORD_W-1:0]      diff;
  logic                             gap_ok;
  logic                             do_store;
  logic [PTR_W-1:0]                 slot_ptr;
  logic                             slot_ok;
  logic [EXT_W-1:0]                 wp_ext;
  logic [EXT_W-1:0]                 rp_ext;

  // lookup address: newest entry for a store, the slot for a read
  always_comb begin
    rd_ph = zctr_pkg::phase_clamp(rd_req.phase);
    if (rd_req.is_read) begin
      raddr = {rd_ph, PTR_W'(rd_req.slot)};
    end else begin
      raddr = {rd_ph, ptr_prev(wp_r[rd_ph])};
    end
  end

  // gap check and pointer update
  always_comb begin
    ph       = zctr_pkg::phase_clamp(op.phase);
    cur_wp   = wp_r[ph];
    cur_rp   = rp_r[ph];
    cur_wrap = wrap_r[ph];
    diff     = word - rdata;
    gap_ok   = (cur_wp == cur_rp) || (diff >= min_gap);
    do_store = op.commit && op.try_store && !op.clear && gap_ok;
    wp_adv   = ptr_next(cur_wp);
    rp_adv   = (wp_adv == cur_rp) ? ptr_next(wp_adv) : cur_rp;
    if (op.clear) begin
      new_wp = '0;
      new_rp = '0;
    end else if (do_store) begin
      new_wp = wp_adv;
      new_rp = rp_adv;
    end else begin
      new_wp = cur_wp;
      new_rp = cur_rp;
    end
    waddr = {ph, cur_wp};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < zctr_pkg::PHASE_CNT; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
      wrap_r <= '0;
    end else if (op.commit && op.clear) begin
      for (int i = 0; i < zctr_pkg::PHASE_CNT; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
      wrap_r <= '0;
    end else if (do_store) begin
      wp_r[ph] <= wp_adv;
      rp_r[ph] <= rp_adv;
      if (cur_wp == PTR_LAST) begin
        wrap_r[ph] <= 1'b1;
      end
    end
  end

  // ring words
  zctr_ram #(
    .WIDTH (zctr_pkg::WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (waddr),
    .wdata (word),
    .re    (rd_req.en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // slot was written since clear: ring wrapped once, or slot below write ptr
  always_comb begin
    slot_ptr = PTR_W'(op.slot);
    slot_ok  = (EXT_W'(op.slot) < EXT_W'(RING_DEPTH)) &&
               (cur_wrap || (slot_ptr < cur_wp));
    wp_ext   = EXT_W'(new_wp);
    rp_ext   = EXT_W'(new_rp);
    rsp.stored   = do_store;
    rsp.wr_index = wp_ext[2:0];
    rsp.rd_index = rp_ext[2:0];
    rsp.entry    = slot_ok ? rdata : '0;
  end

endmodule

/* src/zero_cross_timestamp_ring_unit.sv */
// ----------------------------------------------------------------------------
// zero_cross_timestamp_ring_unit: mains zero-crossing timestamp logger
// Six overwrite-oldest rings (rising and falling for three phases) with a
// minimum-gap filter, derived falling crossings, entry reads and clear.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in_     | input     | in_valid/in_stall  | in_data  (cmd..slot)
//   out_    | output    | out_valid/out_stall| out_data (stored flags..)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The accept cycle issues the ring RAM lookup; its registered read data is
// compared and written back in the execute cycle.
// The result register frees the input side while a result waits.
// A stalled output holds the execute cycle until the result register frees.
// Reset (and the clear command) zero the pointers; no RAM sweep is needed.
// ----------------------------------------------------------------------------
module zero_cross_timestamp_ring_unit #(
  parameter int unsigned RING_DEPTH = zctr_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  zctr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output zctr_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [zctr_pkg::WORD_W-1:0] cfg_data
);

  // configuration registers
  logic signed [zctr_pkg::WORD_W-1:0]  time_offset_r;
  logic [zctr_pkg::WORD_W-1:0]         min_gap_r;
  logic [zctr_pkg::WORD_W-1:0]         half_cycle_r;
  logic [zctr_pkg::PHASE_CNT-1:0]      neg_pin_mask_r;

  // control
  zctr_pkg::state_t                    state_r;
  zctr_pkg::state_t                    state_nxt;
  logic                                in_acc;
  logic                                go;
  logic                                out_valid_r;
  zctr_pkg::out_item_t                 out_data_r;
  zctr_pkg::out_item_t                 out_nxt;

  // item held across the execute cycle
  logic [1:0]                          cmd_r;
  logic [1:0]                          phase_r;
  logic                                falling_r;
  logic [2:0]                          slot_r;
  logic                                phase_ok_r;
  logic                                rise_try_r;
  logic                                fall_try_r;
  logic [zctr_pkg::WORD_W-1:0]         rise_word_r;
  logic [zctr_pkg::WORD_W-1:0]         fall_word_r;

  // accept-side decode
  logic                                phase_ok;
  logic                                own_pin;
  logic                                is_event;
  logic [3:0]                          mask_ext;
  logic [zctr_pkg::WORD_W-1:0]         t_adj;
  logic [zctr_pkg::WORD_W-1:0]         t_half;

  zctr_pkg::bank_rd_t                  rise_rd;
  zctr_pkg::bank_rd_t                  fall_rd;
  zctr_pkg::bank_op_t                  rise_op;
  zctr_pkg::bank_op_t                  fall_op;
  zctr_pkg::bank_rsp_t                 rise_rsp;
  zctr_pkg::bank_rsp_t                 fall_rsp;
  zctr_pkg::bank_rsp_t                 sel_rsp;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_offset_r  <= zctr_pkg::TIME_OFFSET_RST;
      min_gap_r      <= zctr_pkg::MIN_GAP_RST;
      half_cycle_r   <= zctr_pkg::HALF_CYCLE_RST;
      neg_pin_mask_r <= zctr_pkg::NEG_PIN_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (zctr_pkg::cfg_idx_t'(cfg_index))
        zctr_pkg::CFG_TIME_OFFSET:  time_offset_r  <= cfg_data;
        zctr_pkg::CFG_MIN_GAP:      min_gap_r      <= cfg_data;
        zctr_pkg::CFG_HALF_CYCLE:   half_cycle_r   <= cfg_data;
        zctr_pkg::CFG_NEG_PIN_MASK: neg_pin_mask_r <= cfg_data[zctr_pkg::PHASE_CNT-1:0];
        default: ;
      endcase
    end
  end

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zctr_pkg::ST_IDLE: if (in_acc) state_nxt = zctr_pkg::ST_EXEC;
      zctr_pkg::ST_EXEC: if (go)     state_nxt = zctr_pkg::ST_IDLE;
      default:           state_nxt = zctr_pkg::ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_stall = 1'b1;
    go       = 1'b0;
    unique case (state_r)
      zctr_pkg::ST_IDLE: in_stall = 1'b0;
      zctr_pkg::ST_EXEC: go       = !(out_valid_r && out_stall);
      default: ;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zctr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accept decode: adjusted time, derived falling time, target rings
  always_comb begin
    phase_ok = (in_data.phase != zctr_pkg::PHASE_NONE);
    mask_ext = {1'b0, neg_pin_mask_r};
    own_pin  = mask_ext[in_data.phase];
    is_event = phase_ok && (in_data.cmd == zctr_pkg::CMD_EVENT);
    t_adj    = in_data.stamp + $unsigned(time_offset_r);
    t_half   = t_adj - half_cycle_r;

    rise_rd.en      = in_acc && phase_ok;
    rise_rd.is_read = (in_data.cmd == zctr_pkg::CMD_READ) && !in_data.falling;
    rise_rd.phase   = in_data.phase;
    rise_rd.slot    = in_data.slot;

    fall_rd.en      = in_acc && phase_ok;
    fall_rd.is_read = (in_data.cmd == zctr_pkg::CMD_READ) && in_data.falling;
    fall_rd.phase   = in_data.phase;
    fall_rd.slot    = in_data.slot;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r       <= in_data.cmd;
      phase_r     <= in_data.phase;
      falling_r   <= in_data.falling;
      slot_r      <= in_data.slot;
      phase_ok_r  <= phase_ok;
      rise_try_r  <= is_event && !in_data.falling;
      fall_try_r  <= is_event && (in_data.falling ? own_pin : !own_pin);
      rise_word_r <= t_adj;
      fall_word_r <= in_data.falling ? t_adj : t_half;
    end
  end

  // bank updates in the execute cycle
  always_comb begin
    rise_op.commit    = go && phase_ok_r;
    rise_op.try_store = rise_try_r;
    rise_op.clear     = (cmd_r == zctr_pkg::CMD_CLEAR);
    rise_op.phase     = phase_r;
    rise_op.slot      = slot_r;

    fall_op.commit    = go && phase_ok_r;
    fall_op.try_store = fall_try_r;
    fall_op.clear     = (cmd_r == zctr_pkg::CMD_CLEAR);
    fall_op.phase     = phase_r;
    fall_op.slot      = slot_r;
  end

  zctr_bank #(
    .RING_DEPTH (RING_DEPTH)
  ) u_rise_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .min_gap (min_gap_r),
    .rd_req  (rise_rd),
    .op      (rise_op),
    .word    (rise_word_r),
    .rsp     (rise_rsp)
  );

  zctr_bank #(
    .RING_DEPTH (RING_DEPTH)
  ) u_fall_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .min_gap (min_gap_r),
    .rd_req  (fall_rd),
    .op      (fall_op),
    .word    (fall_word_r),
    .rsp     (fall_rsp)
  );

  // result assembly
  always_comb begin
    sel_rsp = falling_r ? fall_rsp : rise_rsp;
    out_nxt = '0;
    if (phase_ok_r) begin
      out_nxt.rise_stored = rise_rsp.stored;
      out_nxt.fall_stored = fall_rsp.stored;
      out_nxt.wr_index    = sel_rsp.wr_index;
      out_nxt.rd_index    = sel_rsp.rd_index;
      out_nxt.entry       = (cmd_r == zctr_pkg::CMD_READ) ? sel_rsp.entry : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/zctr_checker.sv */
// ----------------------------------------------------------------------------
// zctr_checker: port-level assertions for the zero-cross timestamp rings
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module zctr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input zctr_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input zctr_pkg::out_item_t         out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // one transaction in flight: input side closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is executing");

  // a store never carries read data
  a_store_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.rise_stored || out_data.fall_stored) |->
      out_data.entry == '0)
    else $error("stored flag together with nonzero entry");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind zero_cross_timestamp_ring_unit zctr_checker u_zctr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/zctr_ring_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zctr_ring_checker: result prediction for the zero-cross timestamp rings
// Watches the input, result and register write transactions. It keeps its own
// copy of the six rings, their pointers and the registers. Every result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module zctr_ring_checker #(
  parameter int unsigned DEPTH = zctr_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  zctr_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  zctr_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [zctr_pkg::WORD_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          open_count
);
  import zctr_pkg::*;

  localparam int unsigned RINGS = 2 * PHASE_CNT;

  // ring contents, next write position and oldest entry per ring
  logic [WORD_W-1:0]    ring_mem [RINGS][DEPTH];
  int unsigned          head [RINGS];
  int unsigned          tail [RINGS];

  // register copies
  logic [WORD_W-1:0]    offset_reg;
  logic [WORD_W-1:0]    gap_reg;
  logic [WORD_W-1:0]    half_reg;
  logic [PHASE_CNT-1:0] pin_mask;

  out_item_t            due_reports [$];
  int                   mismatches = 0;

  function automatic void clear_rings();
    for (int r = 0; r < RINGS; r++) begin
      head[r] = 0;
      tail[r] = 0;
      for (int s = 0; s < DEPTH; s++) ring_mem[r][s] = '0;
    end
  endfunction

  function automatic int unsigned next_pos(input int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // append a word unless it lies closer than the minimum gap to the newest one
  function automatic logic push_word(input int unsigned r, input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] span;
    int unsigned       last;
    if (head[r] != tail[r]) begin
      last = (head[r] == 0) ? DEPTH - 1 : head[r] - 1;
      span = word - ring_mem[r][last];
      if (span < gap_reg) return 1'b0;
    end
    ring_mem[r][head[r]] = word;
    head[r] = next_pos(head[r]);
    // full ring: drop the oldest entry
    if (head[r] == tail[r]) tail[r] = next_pos(head[r]);
    return 1'b1;
  endfunction

  // apply one input transaction and return the result it must produce
  function automatic out_item_t ring_step(input in_item_t it);
    out_item_t         res;
    int unsigned       rise_r;
    int unsigned       fall_r;
    int unsigned       r;
    logic [WORD_W-1:0] t;
    logic              own_pin;
    res = '0;
    if (it.phase == PHASE_NONE) return res;
    rise_r  = 2 * int'(it.phase);
    fall_r  = rise_r + 1;
    r       = rise_r + int'(it.falling);
    t       = it.stamp + offset_reg;
    own_pin = pin_mask[it.phase];
    case (cmd_t'(it.cmd))
      CMD_EVENT: begin
        if (!it.falling) begin
          res.rise_stored = push_word(rise_r, t);
          // no falling pin: derive the falling crossing half a cycle back
          if (!own_pin) res.fall_stored = push_word(fall_r, t - half_reg);
        end else if (own_pin) begin
          res.fall_stored = push_word(fall_r, t);
        end
      end
      CMD_READ: begin
        if (it.slot < DEPTH) res.entry = ring_mem[r][it.slot];
      end
      CMD_CLEAR: clear_rings();
      default: ;
    endcase
    res.wr_index = head[r][IDX_W-1:0];
    res.rd_index = tail[r][IDX_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // sample all three channels on the clock edge
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      offset_reg = TIME_OFFSET_RST;
      gap_reg    = MIN_GAP_RST;
      half_reg   = HALF_CYCLE_RST;
      pin_mask   = NEG_PIN_MASK_RST;
      clear_rings();
      due_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TIME_OFFSET:  offset_reg = cfg_data;
          CFG_MIN_GAP:      gap_reg    = cfg_data;
          CFG_HALF_CYCLE:   half_reg   = cfg_data;
          CFG_NEG_PIN_MASK: pin_mask   = cfg_data[PHASE_CNT-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_reports.push_back(ring_step(in_data));
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          flag_mismatch("result transaction with none due, entry", '0, out_data.entry);
        end else begin
          want = due_reports.pop_front();
          if (out_data.rise_stored !== want.rise_stored)
            flag_mismatch("rise_stored", WORD_W'(want.rise_stored),
                          WORD_W'(out_data.rise_stored));
          if (out_data.fall_stored !== want.fall_stored)
            flag_mismatch("fall_stored", WORD_W'(want.fall_stored),
                          WORD_W'(out_data.fall_stored));
          if (out_data.wr_index !== want.wr_index)
            flag_mismatch("wr_index", WORD_W'(want.wr_index), WORD_W'(out_data.wr_index));
          if (out_data.rd_index !== want.rd_index)
            flag_mismatch("rd_index", WORD_W'(want.rd_index), WORD_W'(out_data.rd_index));
          if (out_data.entry !== want.entry)
            flag_mismatch("entry", want.entry, out_data.entry);
        end
      end
    end
    fail_count <= mismatches;
    open_count <= due_reports.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for zero_cross_timestamp_ring_unit
// Directed crossings, reads and clears under the reset registers, then random
// phases under several register settings, with bursty input, a patterned
// result stall and one long result hold-off. Checking is done by
// zctr_ring_checker; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module testbench;
  import zctr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [1:0]  PH_A        = 2'd0;
  localparam logic [1:0]  PH_B        = 2'd1;
  localparam logic [1:0]  PH_C        = 2'd2;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_TIME_OFFSET;
  logic [WORD_W-1:0] cfg_data  = '0;

  int                fail_tally;
  int                open_tally;
  bit                hold_req     = 1'b0;
  int unsigned       burst_left   = 0;
  int unsigned       quiet_cycles = 0;
  logic [WORD_W-1:0] line_clock;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  zero_cross_timestamp_ring_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zctr_ring_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_tally),
    .open_count (open_tally)
  );

  // one input transaction; paced items end bursts with a random gap
  task automatic offer(input in_item_t it, input bit paced);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!paced) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_tally != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic load_config(input logic [WORD_W-1:0] off_v, input logic [WORD_W-1:0] gap_v,
                             input logic [WORD_W-1:0] half_v, input logic [2:0] mask_v);
    put_reg(CFG_TIME_OFFSET, off_v);
    put_reg(CFG_MIN_GAP, gap_v);
    put_reg(CFG_HALF_CYCLE, half_v);
    put_reg(CFG_NEG_PIN_MASK, WORD_W'(mask_v));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk(input cmd_t c, input logic [1:0] ph, input logic f,
                                  input logic [WORD_W-1:0] st, input logic [2:0] sl);
    in_item_t it;
    it.cmd     = c;
    it.phase   = ph;
    it.falling = f;
    it.stamp   = st;
    it.slot    = sl;
    return it;
  endfunction

  // mostly crossings on a running time base, some reads and clears, some noise
  task automatic draw_item(input logic [WORD_W-1:0] spacing, output in_item_t it,
                           output bit counts);
    int unsigned       pick;
    logic [WORD_W-1:0] adv;
    pick    = $urandom_range(0, 99);
    counts  = 1'b1;
    it      = '0;
    it.slot = 3'($urandom_range(0, 7));
    if (pick < 62) begin
      case ($urandom_range(0, 3))
        0:       adv = $urandom_range(0, spacing);      // usually inside the gap
        1:       adv = spacing;
        default: adv = spacing + $urandom_range(0, spacing);
      endcase
      line_clock += adv;
      it.cmd     = CMD_EVENT;
      it.phase   = 2'($urandom_range(0, 2));
      it.falling = ($urandom_range(0, 3) == 0);
      it.stamp   = line_clock;
    end else if (pick < 80) begin
      it.cmd     = CMD_READ;
      it.phase   = 2'($urandom_range(0, 2));
      it.falling = 1'($urandom_range(0, 1));
      it.stamp   = $urandom;
    end else if (pick < 84) begin
      it.cmd     = CMD_CLEAR;
      it.phase   = 2'($urandom_range(0, 2));
      it.stamp   = $urandom;
    end else begin
      it.cmd     = 2'($urandom_range(0, 3));
      it.phase   = 2'($urandom_range(0, 3));
      it.falling = 1'($urandom_range(0, 1));
      it.stamp   = $urandom;
      counts     = (it.phase != PHASE_NONE) && (it.cmd != CMD_NOP);
    end
  endtask

  // squeeze: ask for the long result hold-off and send back to back meanwhile
  task automatic run_random(input int want, input logic [WORD_W-1:0] spacing,
                            input bit squeeze);
    in_item_t it;
    bit       counts;
    int       done;
    done = 0;
    if (squeeze) hold_req <= 1'b1;
    while (done < want) begin
      draw_item(spacing, it, counts);
      offer(it, !(squeeze && done < 40));
      if (counts) done++;
    end
    if (squeeze) hold_req <= 1'b0;
  endtask

  task automatic run_directed();
    offer(mk(CMD_READ,  PH_A, 1'b0, 32'h0, 3'd0), 1'b1);          // empty ring read
    offer(mk(CMD_EVENT, PH_A, 1'b0, 32'h0, 3'd0), 1'b1);          // empty: no gap check
    offer(mk(CMD_EVENT, PH_A, 1'b0, 32'd1000, 3'd7), 1'b1);       // too close, dropped
    offer(mk(CMD_EVENT, PH_A, 1'b1, 32'd5, 3'd0), 1'b1);          // falling, no own pin
    offer(mk(CMD_EVENT, PH_B, 1'b0, 32'hFFFF_FFFF, 3'd0), 1'b1);
    offer(mk(CMD_EVENT, PH_B, 1'b0, 32'h0001_E846, 3'd0), 1'b1);  // wraps, one short
    offer(mk(CMD_EVENT, PH_B, 1'b0, 32'h0001_E847, 3'd0), 1'b1);  // exactly the gap
    offer(mk(CMD_EVENT, PHASE_NONE, 1'b0, 32'h1234_5678, 3'd3), 1'b1);
    offer(mk(CMD_NOP,   PH_C, 1'b1, 32'hFFFF_FFFF, 3'd7), 1'b1);
    offer(mk(CMD_READ,  PH_A, 1'b0, 32'h0, 3'd0), 1'b1);
    offer(mk(CMD_READ,  PH_A, 1'b1, 32'h0, 3'd0), 1'b1);
    offer(mk(CMD_READ,  PH_B, 1'b0, 32'h0, 3'd1), 1'b1);
    // overfill one ring so the oldest entries get overwritten
    for (int k = 1; k <= 9; k++) offer(mk(CMD_EVENT, PH_C, 1'b0, k * 300000, 3'd0), 1'b1);
    offer(mk(CMD_READ,  PH_C, 1'b0, 32'h0, 3'd7), 1'b1);
    offer(mk(CMD_READ,  PH_C, 1'b1, 32'h0, 3'd0), 1'b1);
    offer(mk(CMD_CLEAR, PH_B, 1'b1, 32'h0, 3'd0), 1'b1);
    offer(mk(CMD_READ,  PH_C, 1'b0, 32'h0, 3'd7), 1'b1);
  endtask

  // result side stall pattern, plus one long hold-off on request
  initial begin : rx_pace
    int unsigned seg;
    int unsigned pct;
    int unsigned k;
    bit          held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        seg = $urandom_range(8, 48);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 85;
        endcase
        k = 0;
        while (k < seg && !(hold_req && !held)) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
          k++;
        end
      end
    end
  end

  // watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] gap_pick;
    line_clock = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    run_directed();
    drain();

    load_config(32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 3'b111);
    run_random(110, 32'd5000, 1'b0);
    drain();

    load_config(32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 3'b000);
    run_random(50, 32'h3FFF_FFFF, 1'b0);
    drain();

    gap_pick = $urandom_range(1000, 300000);
    load_config($urandom, gap_pick, $urandom, 3'($urandom_range(0, 7)));
    run_random(120, gap_pick, 1'b1);
    drain();

    load_config(TIME_OFFSET_RST, MIN_GAP_RST, HALF_CYCLE_RST, 3'b101);
    run_random(110, MIN_GAP_RST, 1'b0);
    drain();

    load_config(32'd0, 32'd1, HALF_CYCLE_RST, 3'b010);
    run_random(110, 32'd64, 1'b0);
    drain();

    repeat (10) @(posedge clk);
    if (fail_tally == 0 && open_tally == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
